// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checkers of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
// Shared widths, codes and types of the stable priority task queue.
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int CMD_W  = 2;
    localparam int ID_W   = 16;
    localparam int PRI_W  = 8;
    localparam int TIME_W = 16;
    localparam int STAT_W = 3;

    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXEC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST = 2'd2;

    localparam logic [STAT_W-1:0] ST_ADDED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXEC   = 3'd1;
    localparam logic [STAT_W-1:0] ST_LISTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRI_W-1:0]  pri;
        logic [TIME_W-1:0] run_time;
    } t_task;

endpackage

// ----- rtl/spq_ifs.sv -----
// Command and response channel interfaces of the task queue.
interface spq_cmd_if import spq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   task_id;
    logic [PRI_W-1:0]  task_priority;
    logic [TIME_W-1:0] run_time;

    modport source (output valid, command, task_id, task_priority, run_time, input ready);
    modport sink   (input valid, command, task_id, task_priority, run_time, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   out_id;
    logic [PRI_W-1:0]  out_priority;
    logic [TIME_W-1:0] out_time;
    logic              last;

    modport source (output valid, status, out_id, out_priority, out_time, last, input ready);
    modport sink   (input valid, status, out_id, out_priority, out_time, last, output ready);
endinterface

// ----- rtl/stable_priority_task_queue.sv -----
// Stable priority task queue: up to DEPTH tasks held in service order in a register
// file, highest priority first and first-come among equal priorities. One word is
// taken at a time; i_in.ready is high only while the sequencer is idle. A single
// read port and priority comparator walk the store one entry per cycle: an add
// scans from the tail and shifts lower-priority entries back, then posts the
// response; an execute posts the front task and shifts the rest forward; a list
// sends one word per stored entry per cycle while the output is free. Full and
// empty commands go straight to the response state; an unused command is taken
// with no response. A registered output stage holds each response word until it
// is taken.
module stable_priority_task_queue import spq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_cmd_if.sink    i_in,
    spq_rsp_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_REMOVE,
        S_LIST,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        t_task             item;
        logic              last;
    } t_rsp;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    t_task             r_new, n_new;
    t_task             r_pend, n_pend;
    logic [STAT_W-1:0] r_pend_status, n_pend_status;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out, n_out;
    t_task             r_store [DEPTH];

    logic [IDX_W-1:0]  w_rd_addr;
    t_task             w_rd;
    logic              w_we;
    logic [IDX_W-1:0]  w_wa;
    t_task             w_wd;
    logic              w_slot_free;
    logic              w_accept;
    logic [CNT_W-1:0]  w_ptr_inc;
    logic              w_list_last;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_ptr_inc   = CNT_W'(r_ptr) + CNT_W'(1);
    assign w_list_last = (w_ptr_inc == r_count);

    always_comb begin
        unique case (r_state)
            S_INSERT: w_rd_addr = r_ptr - IDX_W'(1);
            S_REMOVE: w_rd_addr = w_ptr_inc[IDX_W-1:0];
            S_LIST:   w_rd_addr = r_ptr;
            default:  w_rd_addr = '0;
        endcase
    end

    assign w_rd = r_store[w_rd_addr];

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_ptr         = r_ptr;
        n_new         = r_new;
        n_pend        = r_pend;
        n_pend_status = r_pend_status;
        n_out         = r_out;
        n_out_valid   = r_out_valid && !o_out.ready;
        w_we          = 1'b0;
        w_wa          = r_ptr;
        w_wd          = w_rd;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.command)
                        CMD_ADD: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_pend        = '0;
                                n_pend_status = ST_FULL;
                                n_state       = S_RESP;
                            end else begin
                                n_new.id       = i_in.task_id;
                                n_new.pri      = i_in.task_priority;
                                n_new.run_time = i_in.run_time;
                                n_ptr          = r_count[IDX_W-1:0];
                                n_state        = S_INSERT;
                            end
                        end
                        CMD_EXEC: begin
                            if (r_count == '0) begin
                                n_pend        = '0;
                                n_pend_status = ST_EMPTY;
                                n_state       = S_RESP;
                            end else begin
                                n_pend        = w_rd;
                                n_pend_status = ST_EXEC;
                                n_ptr         = '0;
                                n_state       = S_REMOVE;
                            end
                        end
                        CMD_LIST: begin
                            if (r_count == '0) begin
                                n_pend        = '0;
                                n_pend_status = ST_EMPTY;
                                n_state       = S_RESP;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_LIST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INSERT: begin
                w_we = 1'b1;
                if (r_ptr == '0 || w_rd.pri >= r_new.pri) begin
                    w_wd          = r_new;
                    n_count       = r_count + CNT_W'(1);
                    n_pend        = '0;
                    n_pend_status = ST_ADDED;
                    n_state       = S_RESP;
                end else begin
                    w_wd  = w_rd;
                    n_ptr = r_ptr - IDX_W'(1);
                end
            end
            S_REMOVE: begin
                if (w_ptr_inc >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_RESP;
                end else begin
                    w_we  = 1'b1;
                    w_wd  = w_rd;
                    n_ptr = w_ptr_inc[IDX_W-1:0];
                end
            end
            S_LIST: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out.status = ST_LISTED;
                    n_out.item   = w_rd;
                    n_out.last   = w_list_last;
                    if (w_list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr = w_ptr_inc[IDX_W-1:0];
                    end
                end
            end
            S_RESP: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out.status = r_pend_status;
                    n_out.item   = r_pend;
                    n_out.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ptr         <= n_ptr;
        r_new         <= n_new;
        r_pend        <= n_pend;
        r_pend_status <= n_pend_status;
        r_out         <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_wa] <= w_wd;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.out_id       = r_out.item.id;
    assign o_out.out_priority = r_out.item.pri;
    assign o_out.out_time     = r_out.item.run_time;
    assign o_out.last         = r_out.last;

endmodule

// ----- rtl/spq_checker.sv -----
// Port-level checker for the task queue, bound to the top level.
`include "assert_macros.svh"

module spq_checker import spq_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [CMD_W-1:0]  i_in_command,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [STAT_W-1:0] i_out_status,
    input logic [ID_W-1:0]   i_out_id,
    input logic [PRI_W-1:0]  i_out_priority,
    input logic [TIME_W-1:0] i_out_time,
    input logic              i_out_last
);

    logic w_in_acc;
    logic w_no_data;
    logic w_known_cmd;

    assign w_in_acc    = i_in_valid && i_in_ready;
    assign w_known_cmd = (i_in_command == CMD_ADD) || (i_in_command == CMD_EXEC)
                      || (i_in_command == CMD_LIST);
    assign w_no_data   = (i_out_status == ST_ADDED) || (i_out_status == ST_EMPTY)
                      || (i_out_status == ST_FULL);

    `SPQ_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_id) && $stable(i_out_status) && $stable(i_out_last), "response word changed while stalled")
    `SPQ_ASSERT_NXT(a_busy_after_cmd, w_in_acc && w_known_cmd, !i_in_ready, "ready stayed high after a valid command")
    `SPQ_ASSERT_IMP(a_zero_payload, i_out_valid && w_no_data, (i_out_id == '0) && (i_out_priority == '0) && (i_out_time == '0), "status word carries task data")
    `SPQ_ASSERT_IMP(a_single_last, i_out_valid && (i_out_status != ST_LISTED), i_out_last, "single response without last")

endmodule

bind stable_priority_task_queue spq_checker u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_command   (i_in.command),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_status   (o_out.status),
    .i_out_id       (o_out.out_id),
    .i_out_priority (o_out.out_priority),
    .i_out_time     (o_out.out_time),
    .i_out_last     (o_out.last)
);

// ----- tb/sv/tb_stable_priority_task_queue.sv -----
// Self-checking testbench of the stable priority task queue: directed table, then random words.
module tb_stable_priority_task_queue;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_PCT      = 7;
    localparam int RAND_ITEMS     = 205;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   id;
        logic [PRI_W-1:0]  pri;
        logic [TIME_W-1:0] rt;
        logic              last;
    } t_rsp;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   id;
        logic [PRI_W-1:0]  pri;
        logic [TIME_W-1:0] rt;
        bit                typed;
        logic [STAT_W-1:0] exp_status;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    spq_cmd_if cmd_bus ();
    spq_rsp_if rsp_bus ();

    stable_priority_task_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_bus.sink),
        .o_out   (rsp_bus.source)
    );

    t_task queued_tasks[$];
    t_rsp  pending_words[$];
    int    n_errors  = 0;
    int    stall_pct = STALL_PCT;
    int    idle_cycles = 0;

    bit                word_typed;
    logic [STAT_W-1:0] word_exp_status;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Priority queue prediction; typed rows replace the predicted words with the table value.
    function automatic void predict_word(input logic [CMD_W-1:0] cmd,
                                         input logic [ID_W-1:0] id,
                                         input logic [PRI_W-1:0] pri,
                                         input logic [TIME_W-1:0] rt,
                                         input bit typed,
                                         input logic [STAT_W-1:0] exp_status);
        t_rsp  fresh[$];
        t_task tsk;
        int    pos;
        case (cmd)
            CMD_ADD: begin
                if (queued_tasks.size() >= DEPTH) begin
                    fresh.push_back('{ST_FULL, '0, '0, '0, 1'b1});
                end else begin
                    tsk.id = id;
                    tsk.pri = pri;
                    tsk.run_time = rt;
                    pos = 0;
                    while (pos < queued_tasks.size() && queued_tasks[pos].pri >= pri)
                        pos++;
                    queued_tasks.insert(pos, tsk);
                    fresh.push_back('{ST_ADDED, '0, '0, '0, 1'b1});
                end
            end
            CMD_EXEC: begin
                if (queued_tasks.size() == 0) begin
                    fresh.push_back('{ST_EMPTY, '0, '0, '0, 1'b1});
                end else begin
                    tsk = queued_tasks.pop_front();
                    fresh.push_back('{ST_EXEC, tsk.id, tsk.pri, tsk.run_time, 1'b1});
                end
            end
            CMD_LIST: begin
                if (queued_tasks.size() == 0) begin
                    fresh.push_back('{ST_EMPTY, '0, '0, '0, 1'b1});
                end else begin
                    foreach (queued_tasks[i])
                        fresh.push_back('{ST_LISTED, queued_tasks[i].id, queued_tasks[i].pri,
                                          queued_tasks[i].run_time,
                                          (i == queued_tasks.size() - 1)});
                end
            end
            default: ;
        endcase
        if (typed && fresh.size() != 0)
            pending_words.push_back('{exp_status, '0, '0, '0, 1'b1});
        else
            foreach (fresh[i])
                pending_words.push_back(fresh[i]);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_rsp want;
        if (i_rst_n) begin
            if (cmd_bus.valid && cmd_bus.ready)
                predict_word(cmd_bus.command, cmd_bus.task_id, cmd_bus.task_priority,
                             cmd_bus.run_time, word_typed, word_exp_status);
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (pending_words.size() == 0) begin
                    $error("unexpected word: status %0d id %0h", rsp_bus.status, rsp_bus.out_id);
                    n_errors++;
                end else begin
                    want = pending_words.pop_front();
                    if (rsp_bus.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                        n_errors++;
                    end
                    if (rsp_bus.out_id !== want.id) begin
                        $error("out_id: expected %0h, got %0h", want.id, rsp_bus.out_id);
                        n_errors++;
                    end
                    if (rsp_bus.out_priority !== want.pri) begin
                        $error("out_priority: expected %0d, got %0d", want.pri,
                               rsp_bus.out_priority);
                        n_errors++;
                    end
                    if (rsp_bus.out_time !== want.rt) begin
                        $error("out_time: expected %0d, got %0d", want.rt, rsp_bus.out_time);
                        n_errors++;
                    end
                    if (rsp_bus.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, rsp_bus.last);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge i_clk)
        rsp_bus.ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                             input logic [PRI_W-1:0] pri, input logic [TIME_W-1:0] rt,
                             input bit typed, input logic [STAT_W-1:0] exp_status);
        while ($urandom_range(99) < stall_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.command       <= cmd;
        cmd_bus.task_id       <= id;
        cmd_bus.task_priority <= pri;
        cmd_bus.run_time      <= rt;
        word_typed            <= typed;
        word_exp_status       <= exp_status;
        do @(posedge i_clk); while (cmd_bus.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    initial begin
        t_stim_row         rows[$];
        logic [CMD_W-1:0]  cmd;
        logic [PRI_W-1:0]  pri;
        int                n_sent;
        int                pick;
        bit                fill_mode;

        i_rst_n               = 1'b0;
        cmd_bus.valid         = 1'b0;
        cmd_bus.command       = CMD_ADD;
        cmd_bus.task_id       = '0;
        cmd_bus.task_priority = '0;
        cmd_bus.run_time      = '0;
        rsp_bus.ready         = 1'b0;
        word_typed            = 1'b0;
        word_exp_status       = ST_ADDED;

        rows.push_back('{CMD_EXEC,   16'h0000, 8'h00, 16'h0000, 1'b1, ST_EMPTY});
        rows.push_back('{CMD_LIST,   16'h0000, 8'h00, 16'h0000, 1'b1, ST_EMPTY});
        rows.push_back('{CMD_UNUSED, 16'hffff, 8'hff, 16'hffff, 1'b0, ST_ADDED});
        rows.push_back('{CMD_ADD,    16'hffff, 8'hff, 16'hffff, 1'b1, ST_ADDED});
        rows.push_back('{CMD_ADD,    16'h0000, 8'h00, 16'h0000, 1'b1, ST_ADDED});
        // ties at both priority extremes: arrival order must hold
        rows.push_back('{CMD_ADD,    16'h1234, 8'hff, 16'h0001, 1'b1, ST_ADDED});
        rows.push_back('{CMD_ADD,    16'h5678, 8'h00, 16'h8000, 1'b1, ST_ADDED});
        rows.push_back('{CMD_LIST,   16'h0000, 8'h00, 16'h0000, 1'b0, ST_ADDED});
        rows.push_back('{CMD_EXEC,   16'h0000, 8'h00, 16'h0000, 1'b0, ST_ADDED});
        for (int k = 0; k < DEPTH - 3; k++)
            rows.push_back('{CMD_ADD, 16'(16'ha5a5 ^ (k * 16'h1111)), 8'((k * 37) % 5 * 60),
                             16'(16'h5a5a + k), 1'b1, ST_ADDED});
        rows.push_back('{CMD_ADD,    16'hbeef, 8'h80, 16'h0042, 1'b1, ST_FULL});
        rows.push_back('{CMD_LIST,   16'h0000, 8'h00, 16'h0000, 1'b0, ST_ADDED});
        rows.push_back('{CMD_UNUSED, 16'h0000, 8'h00, 16'h0000, 1'b0, ST_ADDED});

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i])
            send_word(rows[i].cmd, rows[i].id, rows[i].pri, rows[i].rt,
                      rows[i].typed, rows[i].exp_status);

        n_sent = 0;
        fill_mode = 1'b0;
        while (n_sent < RAND_ITEMS) begin
            stall_pct = (n_sent >= 100 && n_sent < 160) ? 0 : STALL_PCT;
            if (queued_tasks.size() >= DEPTH)
                fill_mode = 1'b0;
            else if (queued_tasks.size() == 0)
                fill_mode = 1'b1;
            pick = $urandom_range(99);
            if (pick < 3)
                cmd = CMD_UNUSED;
            else if (pick < 15)
                cmd = CMD_LIST;
            else if ($urandom_range(99) < (fill_mode ? 72 : 28))
                cmd = CMD_ADD;
            else
                cmd = CMD_EXEC;
            case ($urandom_range(3))
                0:       pri = $urandom_range(1) ? 8'hff : 8'h00;
                1:       pri = 8'(100 + $urandom_range(3));
                default: pri = 8'($urandom_range(255));
            endcase
            send_word(cmd, 16'($urandom), pri, 16'($urandom), 1'b0, ST_ADDED);
            if (cmd != CMD_UNUSED)
                n_sent++;
        end
        cmd_bus.valid <= 1'b0;
        stall_pct = STALL_PCT;

        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && pending_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
